@@ rtl/line_assembler_with_line_queue_defines.svh @@
// Assertion macros used by lna_ctrl.
`ifndef LINE_ASSEMBLER_WITH_LINE_QUEUE_DEFINES_SVH
`define LINE_ASSEMBLER_WITH_LINE_QUEUE_DEFINES_SVH

// Condition holds on every clock edge out of reset.
`define LNA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define LNA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LNA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lna_pkg.sv @@
package lna_pkg;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [2:0] {
		STS_QUEUED   = 3'd0,
		STS_TOO_LONG = 3'd1,
		STS_FULL     = 3'd2,
		STS_CHAR     = 3'd3,
		STS_RD_EMPTY = 3'd4,
		STS_NO_LINE  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_COPY_END,
		ST_RESULT,
		ST_RD_ADDR,
		ST_RD_OUT
	} state_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  out_byte;
		logic        last;
		logic [4:0]  line_length;
		logic [2:0]  lines_waiting;
		logic [31:0] frame_count;
		logic [31:0] byte_count;
	} res_t;

endpackage

@@ rtl/lna_mem.sv @@
module lna_mem #(
	parameter int AW = 5,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [0:(1<<AW)-1];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/lna_ctrl.sv @@
`include "line_assembler_with_line_queue_defines.svh"

module lna_ctrl #(
	parameter int LINE_LEN = 32,
	parameter int QUEUE_DEPTH = 4,
	localparam int FW = $clog2(LINE_LEN),
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  logic              s_cmd,
	input  logic [7:0]        s_byte,
	input  logic [7:0]        s_max_len,
	output logic              m_valid,
	input  logic              m_ready,
	output lna_pkg::res_t     m_res,
	output logic              line_we,
	output logic [FW-1:0]     line_waddr,
	output logic [7:0]        line_wdata,
	output logic [FW-1:0]     line_raddr,
	input  logic [7:0]        line_rdata,
	output logic              q_we,
	output logic [QW+FW-1:0]  q_waddr,
	output logic [7:0]        q_wdata,
	output logic [QW+FW-1:0]  q_raddr,
	input  logic [7:0]        q_rdata
);

	import lna_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t        state_q, state_d;
	logic [FW-1:0] fill_q;
	logic          too_long_q;
	logic [QW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [FW-1:0] qlen_q [0:(1<<QW)-1];
	logic [31:0]   frames_q, bytes_q;
	logic [FW-1:0] idx_q, len_q, n_q;
	logic [QW-1:0] slot_q;
	status_t       sts_q;
	logic          wr_en_s1;
	logic [FW-1:0] wr_idx_s1;
	logic          out_valid_q;
	res_t          out_q;

	logic          acc, is_term, q_full, rd_none, rd_zero, out_free, out_load;
	logic          copy_done, rd_last;
	logic [FW-1:0] head_len, rd_n;
	logic [8:0]    rd_n9;
	logic [QW-1:0] head_nxt, tail_nxt;
	logic [FW+4:0] len_ext;
	logic [CW+2:0] cnt_ext;

	always_comb begin
		is_term   = (s_byte == CH_CR) || (s_byte == CH_LF);
		q_full    = count_q >= CW'(QUEUE_DEPTH);
		rd_none   = (s_max_len == 8'd0) || (count_q == '0);
		head_len  = qlen_q[head_q];
		rd_n9     = (9'(head_len) >= 9'(s_max_len)) ? (9'(s_max_len) - 9'd1) : 9'(head_len);
		rd_n      = rd_n9[FW-1:0];
		rd_zero   = rd_n == '0;
		head_nxt  = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QW'(1);
		tail_nxt  = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QW'(1);
		copy_done = idx_q == (len_q - FW'(1));
		rd_last   = idx_q == n_q;
		out_free  = !out_valid_q || m_ready;
		len_ext   = {5'd0, len_q};
		cnt_ext   = {3'd0, count_q};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					if (!s_cmd) begin
						if (is_term) begin
							if (too_long_q || q_full) begin
								state_d = (too_long_q || fill_q != '0) ? ST_RESULT : ST_IDLE;
							end else if (fill_q != '0) begin
								state_d = ST_COPY;
							end
						end
					end else if (rd_none || rd_zero) begin
						state_d = ST_RESULT;
					end else begin
						state_d = ST_RD_ADDR;
					end
				end
			end
			ST_COPY: begin
				if (copy_done) begin
					state_d = ST_COPY_END;
				end
			end
			ST_COPY_END: state_d = ST_RESULT;
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD_ADDR: state_d = ST_RD_OUT;
			ST_RD_OUT: begin
				if (out_free) begin
					state_d = rd_last ? ST_IDLE : ST_RD_ADDR;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_ready    = 1'b0;
		out_load   = 1'b0;
		line_we    = 1'b0;
		line_waddr = fill_q;
		line_wdata = s_byte;
		line_raddr = idx_q;
		q_we       = wr_en_s1;
		q_waddr    = {tail_q, wr_idx_s1};
		q_wdata    = line_rdata;
		q_raddr    = {slot_q, idx_q};
		case (state_q)
			ST_IDLE: begin
				s_ready = 1'b1;
				line_we = s_valid && !s_cmd && !is_term && !too_long_q &&
					(fill_q < FW'(LINE_LEN - 1));
			end
			ST_RESULT: out_load = out_free;
			ST_RD_OUT: out_load = out_free;
			default: out_load = 1'b0;
		endcase
	end

	assign acc = s_valid && s_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			too_long_q  <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			qlen_q      <= '{default: '0};
			frames_q    <= '0;
			bytes_q     <= '0;
			wr_en_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			wr_en_s1    <= state_q == ST_COPY;
			out_valid_q <= out_load || (out_valid_q && !m_ready);
			if (acc && !s_cmd) begin
				bytes_q <= bytes_q + 32'd1;
				if (is_term) begin
					if (too_long_q) begin
						too_long_q <= 1'b0;
						fill_q     <= '0;
					end else if (fill_q != '0) begin
						fill_q   <= '0;
						frames_q <= frames_q + 32'd1;
					end
				end else if (!too_long_q) begin
					if (fill_q < FW'(LINE_LEN - 1)) begin
						fill_q <= fill_q + FW'(1);
					end else begin
						too_long_q <= 1'b1;
					end
				end
			end
			if (acc && s_cmd && !rd_none) begin
				qlen_q[head_q] <= '0;
				head_q         <= head_nxt;
				count_q        <= count_q - CW'(1);
			end
			if (state_q == ST_COPY_END) begin
				qlen_q[tail_q] <= len_q;
				tail_q         <= tail_nxt;
				count_q        <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_idx_s1 <= idx_q;
		if (acc) begin
			idx_q <= '0;
			if (!s_cmd) begin
				len_q <= too_long_q ? '0 : fill_q;
				sts_q <= too_long_q ? STS_TOO_LONG : (q_full ? STS_FULL : STS_QUEUED);
			end else begin
				len_q  <= rd_none ? '0 : head_len;
				sts_q  <= rd_none ? STS_NO_LINE : STS_RD_EMPTY;
				n_q    <= rd_n - FW'(1);
				slot_q <= head_q;
			end
		end
		if (state_q == ST_COPY) begin
			idx_q <= idx_q + FW'(1);
		end
		if (out_load) begin
			out_q.line_length   <= len_ext[4:0];
			out_q.lines_waiting <= cnt_ext[2:0];
			out_q.frame_count   <= frames_q;
			out_q.byte_count    <= bytes_q;
			if (state_q == ST_RD_OUT) begin
				out_q.status   <= STS_CHAR;
				out_q.out_byte <= q_rdata;
				out_q.last     <= rd_last;
				if (!rd_last) begin
					idx_q <= idx_q + FW'(1);
				end
			end else begin
				out_q.status   <= sts_q;
				out_q.out_byte <= 8'd0;
				out_q.last     <= 1'b1;
			end
		end
	end

	assign m_valid = out_valid_q;
	assign m_res   = out_q;

	`LNA_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(QUEUE_DEPTH), "queue count over depth")
	`LNA_ASSERT_IMPL(a_copy_room, clk, arst_n, state_q == ST_COPY, count_q < CW'(QUEUE_DEPTH), "copy into full queue")
	`LNA_ASSERT_IMPL(a_rd_idx, clk, arst_n, state_q == ST_RD_ADDR || state_q == ST_RD_OUT, idx_q <= n_q, "read index past line")
	`LNA_ASSERT_NEXT(a_push_count, clk, arst_n, state_q == ST_COPY_END, count_q == $past(count_q) + CW'(1), "queue count not advanced")
	`LNA_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= FW'(LINE_LEN - 1), "line fill over limit")

endmodule

@@ rtl/line_assembler_with_line_queue.sv @@
// Push of an ordinary byte: next request taken the cycle after.
// Terminator of an N-character line: states ST_COPY and ST_COPY_END copy it into the line queue
// (one character a cycle through the single line-buffer read port), then ST_RESULT gives the result.
// Dropped line, empty read or no line: the result comes from ST_RESULT, then back to ST_IDLE.
// Read: each character passes ST_RD_ADDR and ST_RD_OUT, out of the queue memory read port.
// Reset clears control state, counters and the queue; line and queue text stay undefined.
module line_assembler_with_line_queue #(
	parameter int LINE_LEN = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // in_byte[7:0], buf_size[15:8]
	input  logic [0:0]  s_tuser,  // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // out_byte, line_length, lines_waiting, frame_count, byte_count
	output logic [2:0]  m_tuser,  // status[2:0]
	output logic        m_tlast
);

	import lna_pkg::*;

	localparam int FW = $clog2(LINE_LEN);
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	res_t             res;
	logic             line_we, q_we;
	logic [FW-1:0]    line_waddr, line_raddr;
	logic [7:0]       line_wdata, line_rdata, q_wdata, q_rdata;
	logic [QW+FW-1:0] q_waddr, q_raddr;

	lna_ctrl #(
		.LINE_LEN(LINE_LEN),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_valid(s_tvalid),
		.s_ready(s_tready),
		.s_cmd(s_tuser[0]),
		.s_byte(s_tdata[7:0]),
		.s_max_len(s_tdata[15:8]),
		.m_valid(m_tvalid),
		.m_ready(m_tready),
		.m_res(res),
		.line_we(line_we),
		.line_waddr(line_waddr),
		.line_wdata(line_wdata),
		.line_raddr(line_raddr),
		.line_rdata(line_rdata),
		.q_we(q_we),
		.q_waddr(q_waddr),
		.q_wdata(q_wdata),
		.q_raddr(q_raddr),
		.q_rdata(q_rdata)
	);

	lna_mem #(
		.AW(FW),
		.DW(8)
	) u_line_mem (
		.clk(clk),
		.wr_en(line_we),
		.wr_addr(line_waddr),
		.wr_data(line_wdata),
		.rd_addr(line_raddr),
		.rd_data(line_rdata)
	);

	lna_mem #(
		.AW(QW + FW),
		.DW(8)
	) u_queue_mem (
		.clk(clk),
		.wr_en(q_we),
		.wr_addr(q_waddr),
		.wr_data(q_wdata),
		.rd_addr(q_raddr),
		.rd_data(q_rdata)
	);

	assign m_tdata = {res.byte_count, res.frame_count, res.lines_waiting,
		res.line_length, res.out_byte};
	assign m_tuser = res.status;
	assign m_tlast = res.last;

endmodule
